// ===== sv/hmd_pkg.sv =====
// Package for the Hamming (63,57) stream decoder: shared widths, types and
// the syndrome / data extraction functions. No dependencies.
`timescale 1ns / 1ps

package hmd_pkg;

   localparam int CW_LEN   = 63;
   localparam int DATA_LEN = 57;
   localparam int CHK_BITS = 6;
   localparam int BYTE_W   = 8;
   localparam int FILL_W   = 6;
   localparam int TOTAL_W  = 32;
   // fill level at and above which the next word completes a codeword
   localparam int FILL_NEAR = CW_LEN - BYTE_W;

   typedef logic [CW_LEN-1:0]   codeword_type;
   typedef logic [DATA_LEN-1:0] data_bits_type;
   typedef logic [CHK_BITS-1:0] syndrome_type;

   typedef struct packed {
      logic         valid;
      codeword_type word;
   } cw_slot_type;

   // positions p (1..63) whose bit k is set; bit p-1 of the mask
   function automatic codeword_type pos_mask(input int k);
      codeword_type m;
      m = '0;
      for (int p = 1; p <= CW_LEN; p++) begin
         m[p-1] = p[k];
      end
      return m;
   endfunction

   function automatic syndrome_type syndrome_of(input codeword_type w);
      syndrome_type s;
      for (int k = 0; k < CHK_BITS; k++) begin
         s[k] = ^(w & pos_mask(k));
      end
      return s;
   endfunction

   // data bits sit at positions that are not powers of two, ascending
   function automatic data_bits_type extract_data(input codeword_type w);
      data_bits_type d;
      int j;
      d = '0;
      j = 0;
      for (int p = 1; p <= CW_LEN; p++) begin
         if ((p & (p - 1)) != 0) begin
            d[j] = w[p-1];
            j++;
         end
      end
      return d;
   endfunction

endpackage

// ===== sv/hmd_if.sv =====
// Stream channel interfaces for the decoder: code bytes in, data bytes out.
// Depends on hmd_pkg for field widths.
`timescale 1ns / 1ps

interface hmd_req_if;
   logic                        valid;
   logic                        ready;
   logic [hmd_pkg::BYTE_W-1:0]  rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hmd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [hmd_pkg::BYTE_W-1:0]  data_byte;
   logic                        last_of_run;
   logic                        word_corrected;
   logic [hmd_pkg::TOTAL_W-1:0] corrected_total;

   modport source (output valid, output data_byte, output last_of_run,
                   output word_corrected, output corrected_total, input ready);
   modport sink   (input valid, input data_byte, input last_of_run,
                   input word_corrected, input corrected_total, output ready);
endinterface

// ===== sv/hmd_front.sv =====
// Front end: takes code bytes and assembles 63-bit codewords, pushing each
// finished codeword into the queue. Depends on hmd_pkg and hmd_req_if.
`timescale 1ns / 1ps

module hmd_front (
   input  logic                 clock,
   input  logic                 reset,
   hmd_req_if.sink              req_bus,
   input  logic                 can_push,
   output hmd_pkg::cw_slot_type push
);

   localparam int COMB_W = hmd_pkg::CW_LEN + hmd_pkg::BYTE_W;

   hmd_pkg::codeword_type      cw_ff, cw_in;
   logic [hmd_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic [hmd_pkg::FILL_W:0]   fill_sum;
   logic [COMB_W-1:0]          combined;
   logic                       take, done;

   // stall only when this word could finish a codeword and there is no room
   assign req_bus.ready = can_push ||
                          (fill_ff < hmd_pkg::FILL_W'(hmd_pkg::FILL_NEAR));
   assign take = req_bus.valid && req_bus.ready;

   always_comb begin
      combined = {{hmd_pkg::BYTE_W{1'b0}}, cw_ff} |
                 (COMB_W'(req_bus.rx_byte) << fill_ff);
      fill_sum = {1'b0, fill_ff} + (hmd_pkg::FILL_W+1)'(hmd_pkg::BYTE_W);
      done     = fill_sum >= (hmd_pkg::FILL_W+1)'(hmd_pkg::CW_LEN);
      if (done) begin
         fill_in = hmd_pkg::FILL_W'(fill_sum - (hmd_pkg::FILL_W+1)'(hmd_pkg::CW_LEN));
         cw_in   = hmd_pkg::CW_LEN'(combined[COMB_W-1:hmd_pkg::CW_LEN]);
      end else begin
         fill_in = fill_sum[hmd_pkg::FILL_W-1:0];
         cw_in   = combined[hmd_pkg::CW_LEN-1:0];
      end
      push.valid = take && done;
      push.word  = combined[hmd_pkg::CW_LEN-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cw_ff   <= '0;
         fill_ff <= '0;
      end else if (take) begin
         cw_ff   <= cw_in;
         fill_ff <= fill_in;
      end
   end

endmodule

// ===== sv/hmd_queue.sv =====
// Short codeword queue between front and back ends.
// Depends on hmd_pkg.
`timescale 1ns / 1ps

module hmd_queue #(
   parameter int DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  hmd_pkg::cw_slot_type push,
   output logic                 can_push,
   input  logic                 pop,
   output hmd_pkg::cw_slot_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   hmd_pkg::codeword_type slots_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]      count_ff;
   logic                  do_push, do_pop;

   assign can_push   = count_ff != CNT_W'(DEPTH);
   assign do_push    = push.valid && can_push;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = count_ff != '0;
   assign head.word  = slots_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push.word;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= bump(wr_ptr_ff);
         if (do_pop)  rd_ptr_ff <= bump(rd_ptr_ff);
         if (do_push && !do_pop)      count_ff <= count_ff + CNT_W'(1);
         else if (do_pop && !do_push) count_ff <= count_ff - CNT_W'(1);
      end
   end

endmodule

// ===== sv/hmd_back.sv =====
// Back end: syndrome stage, correction and data extraction, then a byte
// packer feeding the output register. Depends on hmd_pkg and hmd_rsp_if.
`timescale 1ns / 1ps

module hmd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  hmd_pkg::cw_slot_type head,
   output logic                 pop,
   hmd_rsp_if.source            rsp_bus
);

   localparam int BUF_W = 64;
   localparam int BITS_W = 7;

   // syndrome stage
   logic                  dec_valid_ff;
   hmd_pkg::codeword_type dec_word_ff;
   hmd_pkg::syndrome_type dec_syn_ff;

   // packer
   logic [BUF_W-1:0]           buf_ff, buf_in, rem_buf;
   logic [BITS_W-1:0]          bits_ff, bits_in, bits_after;
   logic                       corr_ff;
   logic [hmd_pkg::TOTAL_W-1:0] total_ff, total_in;

   // output register
   logic                        out_valid_ff;
   logic [hmd_pkg::BYTE_W-1:0]  out_byte_ff;
   logic                        out_last_ff, out_corr_ff;
   logic [hmd_pkg::TOTAL_W-1:0] out_total_ff;

   logic                  out_free, emit_byte, emit_load, corr_now;
   logic [BUF_W-1:0]      flip_oh;
   hmd_pkg::data_bits_type data_now;

   assign out_free  = !out_valid_ff || rsp_bus.ready;
   assign emit_byte = out_free && (bits_ff >= BITS_W'(hmd_pkg::BYTE_W));
   assign pop       = head.valid && (!dec_valid_ff || emit_load);

   always_comb begin
      rem_buf    = emit_byte ? (buf_ff >> hmd_pkg::BYTE_W) : buf_ff;
      bits_after = emit_byte ? bits_ff - BITS_W'(hmd_pkg::BYTE_W) : bits_ff;
      emit_load  = dec_valid_ff && (bits_after < BITS_W'(hmd_pkg::BYTE_W));
      // one-hot of the syndrome; syndrome zero lands in bit 0 and is dropped
      flip_oh    = BUF_W'(1) << dec_syn_ff;
      data_now   = hmd_pkg::extract_data(dec_word_ff ^ flip_oh[BUF_W-1:1]);
      corr_now   = dec_syn_ff != '0;
      total_in   = (corr_now && (total_ff != '1)) ?
                   total_ff + hmd_pkg::TOTAL_W'(1) : total_ff;
      if (emit_load) begin
         buf_in  = rem_buf | (BUF_W'(data_now) << bits_after[2:0]);
         bits_in = bits_after + BITS_W'(hmd_pkg::DATA_LEN);
      end else begin
         buf_in  = rem_buf;
         bits_in = bits_after;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         dec_word_ff <= head.word;
         dec_syn_ff  <= hmd_pkg::syndrome_of(head.word);
      end
      if (emit_byte) begin
         out_byte_ff  <= buf_ff[hmd_pkg::BYTE_W-1:0];
         out_last_ff  <= bits_ff < BITS_W'(2 * hmd_pkg::BYTE_W);
         out_corr_ff  <= corr_ff;
         out_total_ff <= total_ff;
      end
      if (emit_load) begin
         corr_ff <= corr_now;
      end
      if (reset) begin
         dec_valid_ff <= 1'b0;
         buf_ff       <= '0;
         bits_ff      <= '0;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop)            dec_valid_ff <= 1'b1;
         else if (emit_load) dec_valid_ff <= 1'b0;
         buf_ff  <= buf_in;
         bits_ff <= bits_in;
         if (emit_load) total_ff <= total_in;
         if (emit_byte)          out_valid_ff <= 1'b1;
         else if (rsp_bus.ready) out_valid_ff <= 1'b0;
      end
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.data_byte       = out_byte_ff;
   assign rsp_bus.last_of_run     = out_last_ff;
   assign rsp_bus.word_corrected  = out_corr_ff;
   assign rsp_bus.corrected_total = out_total_ff;

endmodule

// ===== sv/hamming_63_57_stream_decoder.sv =====
// Channel   Dir  Fields                                                 Handshake
// req_bus   in   rx_byte[7:0]                                           valid/ready
// rsp_bus   out  data_byte[7:0], last_of_run, word_corrected,
//                corrected_total[31:0]                                  valid/ready
//
// One code byte is taken per cycle while req_bus.ready is high. A codeword
// completes every 7 or 8 bytes and yields 7 or 8 data bytes, sent one per cycle
// by the packer while rsp_bus is ready. A codeword is registered in queue,
// syndrome stage, packer and output register. Synchronous reset clears fill
// levels, queue, count and valid flags. req_bus.ready falls only while the
// codeword queue is full and the current codeword is one byte from completing.
`timescale 1ns / 1ps

module hamming_63_57_stream_decoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   hmd_req_if.sink    req_bus,
   hmd_rsp_if.source  rsp_bus
);

   hmd_pkg::cw_slot_type push, head;
   logic                 can_push, pop;

   hmd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .can_push (can_push),
      .push     (push)
   );

   hmd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .can_push (can_push),
      .pop      (pop),
      .head     (head)
   );

   hmd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

   // a finished codeword must never be dropped at a full queue
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> can_push)
      else $error("codeword pushed into full queue");

   a_pop_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("pop from empty queue");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_bus.valid)
      else $error("output valid right after reset");

   // a completing word is only taken with room in the queue
   a_ready_room: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && !can_push) |-> !push.valid)
      else $error("word accepted without queue room");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the Hamming (63,57) stream decoder: random and directed
// code bytes in, decoded data bytes checked against an in-bench decoder model.
// Depends on hmd_pkg, the hmd_req_if / hmd_rsp_if interfaces and the decoder RTL.
`timescale 1ns / 1ps

module testbench;

   localparam int RANDOM_BYTES = 96;
   localparam int QUIET_TAIL   = 24;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct {
      logic [hmd_pkg::BYTE_W-1:0] code;
      bit                         hold_for_drain;
   } code_item_type;

   typedef struct packed {
      logic [hmd_pkg::BYTE_W-1:0]  data_byte;
      logic                        last_of_run;
      logic                        word_corrected;
      logic [hmd_pkg::TOTAL_W-1:0] corrected_total;
   } data_word_type;

   logic clock;
   logic reset;

   hmd_req_if req_bus ();
   hmd_rsp_if rsp_bus ();

   hamming_63_57_stream_decoder i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   code_item_type pending_code [$];
   data_word_type expected_data [$];
   int            error_count;
   int            cycle_count;

   // stream builder state
   logic [hmd_pkg::BYTE_W-1:0] build_acc;
   int                         build_n;
   longint                     build_bits;

   // decoder model state
   hmd_pkg::codeword_type       cw_bits;
   logic [5:0]                  cw_fill;
   logic [hmd_pkg::BYTE_W-1:0]  pend_bits;
   logic [3:0]                  pend_count;
   logic [hmd_pkg::TOTAL_W-1:0] corr_count;

   int req_gap;
   int rsp_stall;

   always #1 clock = ~clock;

   // XOR of the positions (1..63) holding a one
   function automatic hmd_pkg::syndrome_type position_xor(input hmd_pkg::codeword_type w);
      hmd_pkg::syndrome_type s;
      s = '0;
      for (int p = 1; p <= hmd_pkg::CW_LEN; p++) begin
         if (w[p-1]) s ^= p[hmd_pkg::CHK_BITS-1:0];
      end
      return s;
   endfunction

   function automatic hmd_pkg::codeword_type encode_data(input hmd_pkg::data_bits_type d);
      hmd_pkg::codeword_type cw;
      hmd_pkg::syndrome_type s;
      int                    j;
      cw = '0;
      j = 0;
      for (int p = 1; p <= hmd_pkg::CW_LEN; p++) begin
         if ((p & (p - 1)) != 0) begin
            cw[p-1] = d[j];
            j++;
         end
      end
      // each check bit at 2^k toggles syndrome bit k
      s = position_xor(cw);
      for (int k = 0; k < hmd_pkg::CHK_BITS; k++) begin
         cw[(1 << k) - 1] = s[k];
      end
      return cw;
   endfunction

   task automatic push_bit(input bit b);
      build_acc[build_n] = b;
      build_n++;
      build_bits++;
      if (build_n == hmd_pkg::BYTE_W) begin
         pending_code.push_back('{build_acc, 1'b0});
         build_n = 0;
      end
   endtask

   task automatic push_raw_byte(input logic [hmd_pkg::BYTE_W-1:0] b);
      for (int i = 0; i < hmd_pkg::BYTE_W; i++) push_bit(b[i]);
   endtask

   // pads with noise up to a codeword boundary, then sends one codeword;
   // error positions of 0 mean no flip
   task automatic push_codeword(input hmd_pkg::data_bits_type d, input int err_a,
                                input int err_b);
      hmd_pkg::codeword_type cw;
      while (build_bits % hmd_pkg::CW_LEN != 0) push_bit(1'($urandom_range(0, 1)));
      cw = encode_data(d);
      if (err_a != 0) cw[err_a-1] = ~cw[err_a-1];
      if (err_b != 0) cw[err_b-1] = ~cw[err_b-1];
      for (int p = 1; p <= hmd_pkg::CW_LEN; p++) push_bit(cw[p-1]);
   endtask

   task automatic push_random_codeword();
      hmd_pkg::data_bits_type d;
      int                     sel;
      int                     pa;
      int                     pb;
      d[31:0] = $urandom;
      d[hmd_pkg::DATA_LEN-1:32] = 25'($urandom);
      sel = $urandom_range(0, 9);
      pa = 0;
      pb = 0;
      if (sel >= 4) pa = $urandom_range(1, hmd_pkg::CW_LEN);
      if (sel >= 8) begin
         pb = $urandom_range(1, hmd_pkg::CW_LEN - 1);
         if (pb >= pa) pb++;
      end
      push_codeword(d, pa, pb);
   endtask

   task automatic decode_code_byte(input logic [hmd_pkg::BYTE_W-1:0] code);
      data_word_type         run [8];
      int                    n;
      hmd_pkg::syndrome_type syn;
      logic                  hit;
      n = 0;
      hit = 1'b0;
      for (int i = 0; i < hmd_pkg::BYTE_W; i++) begin
         cw_bits[cw_fill] = code[i];
         cw_fill++;
         if (cw_fill == 6'(hmd_pkg::CW_LEN)) begin
            syn = position_xor(cw_bits);
            hit = (syn != '0);
            if (hit) begin
               cw_bits[syn-1] = ~cw_bits[syn-1];
               if (corr_count != '1) corr_count++;
            end
            for (int p = 1; p <= hmd_pkg::CW_LEN; p++) begin
               if ((p & (p - 1)) != 0) begin
                  pend_bits[pend_count[2:0]] = cw_bits[p-1];
                  pend_count++;
                  if (pend_count == 4'd8) begin
                     run[n] = '{pend_bits, 1'b0, hit, corr_count};
                     n++;
                     pend_bits = '0;
                     pend_count = '0;
                  end
               end
            end
            cw_bits = '0;
            cw_fill = '0;
         end
      end
      for (int k = 0; k < n; k++) begin
         if (k == n - 1) run[k].last_of_run = 1'b1;
         expected_data.push_back(run[k]);
      end
   endtask

   task automatic report_mismatch(input string what,
                                  input logic [hmd_pkg::TOTAL_W-1:0] got,
                                  input logic [hmd_pkg::TOTAL_W-1:0] want);
      $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      error_count++;
   endtask

   // driver: predicts on each accepted code byte, then presents the next one
   always @(posedge clock) begin
      code_item_type item;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) decode_code_byte(req_bus.rx_byte);
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_code.size() == 0) begin
               req_bus.valid <= 1'b0;
            end else if (pending_code[0].hold_for_drain && expected_data.size() != 0) begin
               req_bus.valid <= 1'b0;
            end else begin
               item = pending_code.pop_front();
               req_bus.valid   <= 1'b1;
               req_bus.rx_byte <= item.code;
               if (pending_code.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
                  req_gap = $urandom_range(1, 11);
            end
         end
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall = 0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (pending_code.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
            rsp_stall = $urandom_range(1, 11);
      end
   end

   // monitor
   always @(posedge clock) begin
      data_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_data.size() == 0) begin
            report_mismatch("unexpected data_byte",
                            hmd_pkg::TOTAL_W'(rsp_bus.data_byte), '0);
         end else begin
            want = expected_data.pop_front();
            if (rsp_bus.data_byte !== want.data_byte)
               report_mismatch("data_byte", hmd_pkg::TOTAL_W'(rsp_bus.data_byte),
                               hmd_pkg::TOTAL_W'(want.data_byte));
            if (rsp_bus.last_of_run !== want.last_of_run)
               report_mismatch("last_of_run", hmd_pkg::TOTAL_W'(rsp_bus.last_of_run),
                               hmd_pkg::TOTAL_W'(want.last_of_run));
            if (rsp_bus.word_corrected !== want.word_corrected)
               report_mismatch("word_corrected",
                               hmd_pkg::TOTAL_W'(rsp_bus.word_corrected),
                               hmd_pkg::TOTAL_W'(want.word_corrected));
            if (rsp_bus.corrected_total !== want.corrected_total)
               report_mismatch("corrected_total", rsp_bus.corrected_total,
                               want.corrected_total);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   initial begin
      int directed_n;
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = '0;
      rsp_bus.ready   = 1'b0;
      error_count = 0;
      cycle_count = 0;
      build_acc = '0;
      build_n = 0;
      build_bits = 0;
      cw_bits = '0;
      cw_fill = '0;
      pend_bits = '0;
      pend_count = '0;
      corr_count = '0;

      // directed: error on the last position, on a check bit, a double error
      // (miscorrected), then all-zero and all-one bytes
      push_codeword('0, hmd_pkg::CW_LEN, 0);
      push_codeword('1, 1, 0);
      push_codeword(57'hA5_5A5A_A5A5_5A5A, 32, 5);
      push_raw_byte(8'h00);
      push_raw_byte(8'hFF);
      directed_n = pending_code.size();

      while (pending_code.size() < directed_n + RANDOM_BYTES) begin
         if ($urandom_range(0, 9) < 8) push_random_codeword();
         else repeat ($urandom_range(1, 6)) push_raw_byte(8'($urandom_range(0, 255)));
      end
      // unfinished codeword at the end
      repeat (3) push_raw_byte(8'($urandom_range(0, 255)));
      while (build_n != 0) push_bit(1'($urandom_range(0, 1)));

      pending_code[directed_n].hold_for_drain = 1'b1;
      pending_code[directed_n + RANDOM_BYTES / 2].hold_for_drain = 1'b1;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (pending_code.size() != 0 || req_bus.valid || expected_data.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/hmd_pkg.sv
sv/hmd_if.sv
sv/hmd_front.sv
sv/hmd_queue.sv
sv/hmd_back.sv
sv/hamming_63_57_stream_decoder.sv
dv/testbench.sv
